### hdl/tsia_pkg.sv
// ----------------------------------------------------------------------------
// tsia_pkg
// opcodes, status codes and the control group that travels down the pipeline
// ----------------------------------------------------------------------------
package tsia_pkg;

  localparam logic [2:0] OP_ADD = 3'd0;
  localparam logic [2:0] OP_SUB = 3'd1;
  localparam logic [2:0] OP_MUL = 3'd2;
  localparam logic [2:0] OP_MOD = 3'd3;
  localparam logic [2:0] OP_DIV = 3'd4;
  localparam logic [2:0] OP_QUO = 3'd5;
  localparam logic [2:0] OP_REM = 3'd6;

  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_RCV_TYPE = 3'd1;
  localparam logic [2:0] ST_ARG_TYPE = 3'd2;
  localparam logic [2:0] ST_DIV_ZERO = 3'd3;
  localparam logic [2:0] ST_OVERFLOW = 3'd4;

  localparam int TAG_BITS = 2;

  typedef struct packed {
    logic [2:0] op;
    logic [2:0] status;
    logic       x_neg;
    logic       y_neg;
  } ctrl_t;

endpackage

### hdl/tsia_decode.sv
// ----------------------------------------------------------------------------
// tsia_decode
// first stage: add/sub, tag and zero checks, operand magnitudes
// ----------------------------------------------------------------------------
module tsia_decode #(
  parameter int WORD_BITS = 32
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    en,
  input  logic                    valid_i,
  input  logic [2:0]              opcode,
  input  logic [WORD_BITS-1:0]    rw,
  input  logic [WORD_BITS-1:0]    aw,
  output logic                    valid_r,
  output tsia_pkg::ctrl_t         ctrl_r,
  output logic [WORD_BITS-1:0]    res_r,
  output logic [WORD_BITS-1:0]    ma_r,
  output logic [WORD_BITS-1:0]    mb_r,
  output logic                    mneg_r,
  output logic [WORD_BITS-3:0]    mx_r,
  output logic [WORD_BITS-3:0]    my_r
);

  localparam int N = WORD_BITS - tsia_pkg::TAG_BITS;

  tsia_pkg::ctrl_t        ctrl_nxt;
  logic [WORD_BITS-1:0]   res_nxt;
  logic [WORD_BITS-1:0]   r_sum;
  logic                   ovf;
  logic [WORD_BITS-1:0]   b_w;
  logic [N-1:0]           x_v;
  logic [N-1:0]           y_v;
  logic                   rtag_nz;
  logic                   atag_nz;

  always_comb begin
    rtag_nz = |rw[1:0];
    atag_nz = |aw[1:0];
    r_sum   = (opcode == tsia_pkg::OP_ADD) ? rw + aw : rw - aw;
    ovf     = (opcode == tsia_pkg::OP_ADD) ?
              ((rw[WORD_BITS-1] ^ r_sum[WORD_BITS-1]) & (aw[WORD_BITS-1] ^ r_sum[WORD_BITS-1])) :
              ((rw[WORD_BITS-1] ^ aw[WORD_BITS-1]) & (rw[WORD_BITS-1] ^ r_sum[WORD_BITS-1]));
    b_w     = {{2{aw[WORD_BITS-1]}}, aw[WORD_BITS-1:2]};
    x_v     = rw[WORD_BITS-1:2];
    y_v     = aw[WORD_BITS-1:2];
    res_nxt = '0;
    ctrl_nxt.op     = opcode;
    ctrl_nxt.status = tsia_pkg::ST_OK;
    ctrl_nxt.x_neg  = rw[WORD_BITS-1];
    ctrl_nxt.y_neg  = aw[WORD_BITS-1];
    case (opcode)
      tsia_pkg::OP_ADD, tsia_pkg::OP_SUB: begin
        if (ovf) begin
          ctrl_nxt.status = atag_nz ? tsia_pkg::ST_ARG_TYPE : tsia_pkg::ST_OVERFLOW;
        end else if (|r_sum[1:0]) begin
          ctrl_nxt.status = tsia_pkg::ST_ARG_TYPE;
        end else begin
          res_nxt = r_sum;
        end
      end
      tsia_pkg::OP_MUL: begin
        if (atag_nz) ctrl_nxt.status = tsia_pkg::ST_ARG_TYPE;
      end
      tsia_pkg::OP_MOD, tsia_pkg::OP_DIV, tsia_pkg::OP_QUO, tsia_pkg::OP_REM: begin
        if (opcode == tsia_pkg::OP_QUO && rtag_nz) begin
          ctrl_nxt.status = tsia_pkg::ST_RCV_TYPE;
        end else if (aw == '0) begin
          ctrl_nxt.status = tsia_pkg::ST_DIV_ZERO;
        end else if (atag_nz) begin
          ctrl_nxt.status = tsia_pkg::ST_ARG_TYPE;
        end
      end
      default: begin
        ctrl_nxt.status = tsia_pkg::ST_RCV_TYPE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= valid_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ctrl_r <= ctrl_nxt;
      res_r  <= res_nxt;
      ma_r   <= rw[WORD_BITS-1] ? -rw : rw;
      mb_r   <= aw[WORD_BITS-1] ? -b_w : b_w;
      mneg_r <= rw[WORD_BITS-1] ^ aw[WORD_BITS-1];
      mx_r   <= rw[WORD_BITS-1] ? -x_v : x_v;
      my_r   <= aw[WORD_BITS-1] ? -y_v : y_v;
    end
  end

endmodule

### hdl/tsia_mul.sv
// ----------------------------------------------------------------------------
// tsia_mul
// two-stage multiply: half-width partial products, then sum and checks
// ----------------------------------------------------------------------------
module tsia_mul #(
  parameter int WORD_BITS = 32
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    en,
  input  logic                    valid_i,
  input  tsia_pkg::ctrl_t         ctrl_i,
  input  logic [WORD_BITS-1:0]    res_i,
  input  logic [WORD_BITS-1:0]    ma,
  input  logic [WORD_BITS-1:0]    mb,
  input  logic                    mneg,
  input  logic [WORD_BITS-3:0]    mx_i,
  input  logic [WORD_BITS-3:0]    my_i,
  output logic                    valid_r,
  output tsia_pkg::ctrl_t         ctrl_r,
  output logic [WORD_BITS-1:0]    res_r,
  output logic [WORD_BITS-3:0]    mx_r,
  output logic [WORD_BITS-3:0]    my_r
);

  localparam int H = (WORD_BITS + 1) / 2;

  logic [2*H-1:0]         ma_x;
  logic [2*H-1:0]         mb_x;
  logic [2*H-1:0]         pp_ll_r, pp_lh_r, pp_hl_r, pp_hh_r;
  logic                   va_r;
  tsia_pkg::ctrl_t        ca_r;
  logic [WORD_BITS-1:0]   resa_r;
  logic                   nega_r;
  logic [WORD_BITS-3:0]   mxa_r, mya_r;

  logic [4*H-1:0]         prod;
  logic [WORD_BITS-1:0]   lo;
  logic                   neg;
  logic                   ovf;
  logic [WORD_BITS-1:0]   r_mul;
  tsia_pkg::ctrl_t        ctrl_nxt;
  logic [WORD_BITS-1:0]   res_nxt;

  assign ma_x = (2*H)'(ma);
  assign mb_x = (2*H)'(mb);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r    <= 1'b0;
      valid_r <= 1'b0;
    end else if (en) begin
      va_r    <= valid_i;
      valid_r <= va_r;
    end
  end

  // partial products
  always_ff @(posedge clk) begin
    if (en) begin
      pp_ll_r <= ma_x[H-1:0] * mb_x[H-1:0];
      pp_lh_r <= ma_x[H-1:0] * mb_x[2*H-1:H];
      pp_hl_r <= ma_x[2*H-1:H] * mb_x[H-1:0];
      pp_hh_r <= ma_x[2*H-1:H] * mb_x[2*H-1:H];
      ca_r    <= ctrl_i;
      resa_r  <= res_i;
      nega_r  <= mneg;
      mxa_r   <= mx_i;
      mya_r   <= my_i;
    end
  end

  always_comb begin
    prod = (4*H)'(pp_ll_r) + ((4*H)'(pp_lh_r) << H) + ((4*H)'(pp_hl_r) << H)
         + ((4*H)'(pp_hh_r) << (2*H));
    lo   = prod[WORD_BITS-1:0];
    neg  = nega_r && (|prod);
    ovf  = (|prod[4*H-1:WORD_BITS]) ||
           (neg ? (lo[WORD_BITS-1] && (|lo[WORD_BITS-2:0])) : lo[WORD_BITS-1]);
    r_mul    = neg ? -lo : lo;
    ctrl_nxt = ca_r;
    res_nxt  = resa_r;
    if (ca_r.op == tsia_pkg::OP_MUL && ca_r.status == tsia_pkg::ST_OK) begin
      if (ovf) begin
        ctrl_nxt.status = tsia_pkg::ST_OVERFLOW;
      end else if (|r_mul[1:0]) begin
        ctrl_nxt.status = tsia_pkg::ST_ARG_TYPE;
      end else begin
        res_nxt = r_mul;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ctrl_r <= ctrl_nxt;
      res_r  <= res_nxt;
      mx_r   <= mxa_r;
      my_r   <= mya_r;
    end
  end

endmodule

### hdl/tsia_div_step.sv
// ----------------------------------------------------------------------------
// tsia_div_step
// one restoring division step, one quotient bit per stage
// ----------------------------------------------------------------------------
module tsia_div_step #(
  parameter int WORD_BITS = 32
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    en,
  input  logic                    valid_i,
  input  tsia_pkg::ctrl_t         ctrl_i,
  input  logic [WORD_BITS-1:0]    res_i,
  input  logic [WORD_BITS-3:0]    rem_i,
  input  logic [WORD_BITS-3:0]    quo_i,
  input  logic [WORD_BITS-3:0]    dvs_i,
  output logic                    valid_r,
  output tsia_pkg::ctrl_t         ctrl_r,
  output logic [WORD_BITS-1:0]    res_r,
  output logic [WORD_BITS-3:0]    rem_r,
  output logic [WORD_BITS-3:0]    quo_r,
  output logic [WORD_BITS-3:0]    dvs_r
);

  localparam int N = WORD_BITS - tsia_pkg::TAG_BITS;

  logic [N:0]   sh;
  logic [N:0]   diff;
  logic         ge;

  always_comb begin
    sh   = {rem_i, quo_i[N-1]};
    diff = sh - {1'b0, dvs_i};
    ge   = !diff[N];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= valid_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ctrl_r <= ctrl_i;
      res_r  <= res_i;
      rem_r  <= ge ? diff[N-1:0] : sh[N-1:0];
      quo_r  <= {quo_i[N-2:0], ge};
      dvs_r  <= dvs_i;
    end
  end

endmodule

### hdl/tagged_small_integer_alu_unit.sv
// ----------------------------------------------------------------------------
// tagged_small_integer_alu_unit
// pipelined tagged small-integer alu: add, sub, mul, mod, div, quo, rem
// ----------------------------------------------------------------------------
// One beat in, one beat out, in order. A new operation is taken every cycle
// while in_tready is high. Each one passes through one decode stage, two
// multiply stages, WORD_BITS-2 restoring divide stages (one quotient bit
// each) and the output register. Every operation runs through the whole
// pipeline. The whole pipe advances while the output register is empty or
// being taken; while a result beat waits in the output register with
// out_tready low, the pipe freezes and in_tready drops.
module tagged_small_integer_alu_unit #(
  parameter int WORD_BITS = 32
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_tvalid,
  output logic                         in_tready,
  // opcode [2:0], receiver_word, argument_word, zero fill
  input  logic [((2*WORD_BITS+3+7)/8)*8-1:0] in_tdata,
  output logic                         out_tvalid,
  input  logic                         out_tready,
  // result_word, status [2:0], zero fill
  output logic [((WORD_BITS+3+7)/8)*8-1:0]   out_tdata
);

  localparam int N        = WORD_BITS - tsia_pkg::TAG_BITS;
  localparam int OUT_BITS = ((WORD_BITS + 3 + 7) / 8) * 8;

  // pipe enable: shared by every stage
  logic en;
  assign en        = !out_tvalid || out_tready;
  assign in_tready = en;

  // input fields
  logic [2:0]           opcode;
  logic [WORD_BITS-1:0] receiver_word;
  logic [WORD_BITS-1:0] argument_word;
  assign opcode        = in_tdata[2:0];
  assign receiver_word = in_tdata[WORD_BITS+2:3];
  assign argument_word = in_tdata[2*WORD_BITS+2:WORD_BITS+3];

  // decode stage outputs
  logic                 d_valid;
  tsia_pkg::ctrl_t      d_ctrl;
  logic [WORD_BITS-1:0] d_res, d_ma, d_mb;
  logic                 d_mneg;
  logic [N-1:0]         d_mx, d_my;

  tsia_decode #(.WORD_BITS(WORD_BITS)) u_decode (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .valid_i (in_tvalid),
    .opcode  (opcode),
    .rw      (receiver_word),
    .aw      (argument_word),
    .valid_r (d_valid),
    .ctrl_r  (d_ctrl),
    .res_r   (d_res),
    .ma_r    (d_ma),
    .mb_r    (d_mb),
    .mneg_r  (d_mneg),
    .mx_r    (d_mx),
    .my_r    (d_my)
  );

  // divide chain, index 0 is fed by the multiplier
  logic                 c_valid [0:N];
  tsia_pkg::ctrl_t      c_ctrl  [0:N];
  logic [WORD_BITS-1:0] c_res   [0:N];
  logic [N-1:0]         c_rem   [0:N];
  logic [N-1:0]         c_quo   [0:N];
  logic [N-1:0]         c_dvs   [0:N];

  tsia_mul #(.WORD_BITS(WORD_BITS)) u_mul (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .valid_i (d_valid),
    .ctrl_i  (d_ctrl),
    .res_i   (d_res),
    .ma      (d_ma),
    .mb      (d_mb),
    .mneg    (d_mneg),
    .mx_i    (d_mx),
    .my_i    (d_my),
    .valid_r (c_valid[0]),
    .ctrl_r  (c_ctrl[0]),
    .res_r   (c_res[0]),
    .mx_r    (c_quo[0]),
    .my_r    (c_dvs[0])
  );

  // partial remainder starts at zero, dividend shifts out of quo
  assign c_rem[0] = '0;

  for (genvar i = 0; i < N; i++) begin : g_div
    tsia_div_step #(.WORD_BITS(WORD_BITS)) u_step (
      .clk     (clk),
      .rst_n   (rst_n),
      .en      (en),
      .valid_i (c_valid[i]),
      .ctrl_i  (c_ctrl[i]),
      .res_i   (c_res[i]),
      .rem_i   (c_rem[i]),
      .quo_i   (c_quo[i]),
      .dvs_i   (c_dvs[i]),
      .valid_r (c_valid[i+1]),
      .ctrl_r  (c_ctrl[i+1]),
      .res_r   (c_res[i+1]),
      .rem_r   (c_rem[i+1]),
      .quo_r   (c_quo[i+1]),
      .dvs_r   (c_dvs[i+1])
    );
  end

  // sign fix, floor adjust, range check and retag
  tsia_pkg::ctrl_t      f_ctrl;
  logic [N+1:0]         qs, rs, ys, v;
  logic                 adj;
  logic [2:0]           st_nxt;
  logic [WORD_BITS-1:0] res_nxt;

  always_comb begin
    f_ctrl  = c_ctrl[N];
    qs      = (f_ctrl.x_neg ^ f_ctrl.y_neg) ? -((N+2)'(c_quo[N])) : (N+2)'(c_quo[N]);
    rs      = f_ctrl.x_neg ? -((N+2)'(c_rem[N])) : (N+2)'(c_rem[N]);
    ys      = f_ctrl.y_neg ? -((N+2)'(c_dvs[N])) : (N+2)'(c_dvs[N]);
    adj     = (c_rem[N] != '0) && (f_ctrl.x_neg != f_ctrl.y_neg);
    st_nxt  = f_ctrl.status;
    res_nxt = c_res[N];
    case (f_ctrl.op)
      tsia_pkg::OP_MOD: v = adj ? rs + ys : rs;
      tsia_pkg::OP_DIV: v = adj ? qs - (N+2)'(1) : qs;
      tsia_pkg::OP_QUO: v = qs;
      default:          v = rs;
    endcase
    if ((f_ctrl.op == tsia_pkg::OP_MOD || f_ctrl.op == tsia_pkg::OP_DIV ||
         f_ctrl.op == tsia_pkg::OP_QUO || f_ctrl.op == tsia_pkg::OP_REM) &&
        f_ctrl.status == tsia_pkg::ST_OK) begin
      // small range is an N-bit signed value
      if (!((v[N+1:N-1] == 3'b000) || (v[N+1:N-1] == 3'b111))) begin
        st_nxt  = tsia_pkg::ST_OVERFLOW;
        res_nxt = '0;
      end else begin
        res_nxt = {v[N-1:0], 2'b00};
      end
    end
  end

  // output register
  logic                 out_valid_r;
  logic [WORD_BITS-1:0] out_res_r;
  logic [2:0]           out_st_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= c_valid[N];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_res_r <= res_nxt;
      out_st_r  <= st_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = OUT_BITS'({out_st_r, out_res_r});

endmodule
